// ===== hw/rtl/sras_pkg.sv =====
package sras_pkg;

    localparam int IDX_W    = 17;
    localparam int COL_W    = 16;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ROWS  = 2'd3;

    localparam logic [IDX_W-1:0] GSIZE_MAX = 17'h10000;
    localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BELOW_BASE  = 3'd1,
        ST_BEYOND_SIZE = 3'd2,
        ST_NOT_LOCAL   = 3'd3,
        ST_ROW_FULL    = 3'd4
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic adjust;
        logic chk;
        logic fill_rd;
        logic search;
        logic update;
        logic append;
        logic clear;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic err;
        logic hit;
        logic miss;
    } t_stat;

endpackage

// ===== hw/rtl/sparse_row_assembly_store_top.sv =====
// sparse row assembly store: each input transaction carries one matrix entry (row, col,
// q16.16 value, insert or add). indices lose the index base, are checked against the
// global size and the local row window, and the stored columns of the local row are
// scanned for a match, which is overwritten or saturating-added; otherwise the entry is
// appended to the row, or row full is reported once the row holds CAP entries. exactly
// one result transaction (status, slot, created) comes back per input transaction. the
// column scan reads one stored column per cycle from the single read port of the entry
// memory, stopping at a match or at the row's fill count; a rejected index skips the scan.
// a new input is taken only after the result of the last one is loaded out, and a result
// held by output stall delays the next acceptance until it leaves. after reset a clearing
// pass over all ROWS rows zeroes the row fill counts, and input is stalled until it ends.
// configuration must be written only while the block is idle; the block itself does not
// enforce it.
module sparse_row_assembly_store_top #(
    parameter int ROWS = 256,
    parameter int CAP  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sras_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sras_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [sras_pkg::IDX_W-1:0]          i_row,
    input  logic [sras_pkg::IDX_W-1:0]          i_col,
    input  logic signed [sras_pkg::VAL_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sras_pkg::STATUS_W-1:0]       o_status,
    output logic [sras_pkg::SLOT_W-1:0]         o_slot,
    output logic                                o_created
);

    sras_pkg::t_cmd  cmd;
    sras_pkg::t_stat stat;

    sras_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    sras_dp #(
        .ROWS (ROWS),
        .CAP  (CAP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_created   (o_created)
    );

endmodule

// ===== hw/rtl/sras_dp.sv =====
module sras_dp #(
    parameter int ROWS = 256,
    parameter int CAP  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sras_pkg::t_cmd                      i_cmd,
    output sras_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [sras_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sras_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_func,
    input  logic [sras_pkg::IDX_W-1:0]          i_row,
    input  logic [sras_pkg::IDX_W-1:0]          i_col,
    input  logic signed [sras_pkg::VAL_W-1:0]   i_value,
    output logic [sras_pkg::STATUS_W-1:0]       o_status,
    output logic [sras_pkg::SLOT_W-1:0]         o_slot,
    output logic                                o_created
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW    = $clog2(CAP + 1);
    localparam int DEPTH = ROWS * CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int IDX_W = sras_pkg::IDX_W;
    localparam int COL_W = sras_pkg::COL_W;
    localparam int VAL_W = sras_pkg::VAL_W;

    // configuration
    logic                 r_index_base;
    logic [IDX_W-1:0]     r_global_size;
    logic [15:0]          r_first_row;
    logic [8:0]           r_local_rows;

    // item under work
    logic                 r_func;
    logic [IDX_W-1:0]     r_row;
    logic [IDX_W-1:0]     r_col;
    logic [VAL_W-1:0]     r_value;
    logic                 r_err_base;
    logic [IDX_W-1:0]     r_row_a;
    logic [IDX_W-1:0]     r_col_a;
    sras_pkg::t_status    r_status;
    logic [RW-1:0]        r_r;
    logic [AW-1:0]        r_base;
    logic [KW-1:0]        r_fill_q;
    logic [KW-1:0]        r_slot;
    logic                 r_created;

    // search pipeline
    logic [KW-1:0]        r_k;
    logic                 r_cmp_valid;
    logic [KW-1:0]        r_cmp_k;
    logic [COL_W-1:0]     r_col_q;
    logic [VAL_W-1:0]     r_val_q;

    logic [RW-1:0]        r_clr_cnt;

    sras_pkg::t_status    r_out_status;
    logic [sras_pkg::SLOT_W-1:0] r_out_slot;
    logic                 r_out_created;

    logic [KW-1:0]        fill_mem [ROWS];
    logic [COL_W-1:0]     col_mem  [DEPTH];
    logic [VAL_W-1:0]     val_mem  [DEPTH];

    logic [IDX_W-1:0]     gsize;
    logic [IDX_W-1:0]     first_row_x;
    logic [IDX_W-1:0]     row_off;
    logic                 beyond;
    logic                 not_local;
    logic                 hit;
    logic                 miss;
    logic                 full;
    logic                 adv;
    logic                 issue;
    logic                 append_wr;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [VAL_W:0]       sum;
    logic [VAL_W-1:0]     sat_val;
    logic [VAL_W-1:0]     new_val;

    always_comb begin
        gsize       = (r_global_size > sras_pkg::GSIZE_MAX) ? sras_pkg::GSIZE_MAX
                                                             : r_global_size;
        first_row_x = {1'b0, r_first_row};
        row_off     = r_row_a - first_row_x;
        beyond      = (r_row_a >= gsize) || (r_col_a >= gsize);
        not_local   = (r_row_a < first_row_x) || (row_off >= {8'b0, r_local_rows})
                      || (row_off >= IDX_W'(ROWS));
    end

    assign hit       = r_cmp_valid && (r_col_q == r_col_a[COL_W-1:0]);
    assign miss      = !r_cmp_valid && (r_k == r_fill_q);
    assign full      = (r_fill_q == KW'(CAP));
    assign adv       = i_cmd.search && !hit;
    assign issue     = adv && (r_k != r_fill_q);
    assign append_wr = i_cmd.append && !full;
    assign rd_addr   = r_base + AW'(r_k);
    assign wr_addr   = r_base + AW'(i_cmd.update ? r_cmp_k : r_fill_q);

    // saturating q16.16 add
    always_comb begin
        sum = {r_val_q[VAL_W-1], r_val_q} + {r_value[VAL_W-1], r_value};
        if (sum[VAL_W] != sum[VAL_W-1]) begin
            sat_val = sum[VAL_W] ? sras_pkg::VAL_MIN : sras_pkg::VAL_MAX;
        end else begin
            sat_val = sum[VAL_W-1:0];
        end
        new_val = r_func ? sat_val : r_value;
    end

    assign o_stat.clear_done = (r_clr_cnt == RW'(ROWS - 1));
    assign o_stat.err        = (r_status != sras_pkg::ST_OK);
    assign o_stat.hit        = hit;
    assign o_stat.miss       = miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_base  <= 1'b0;
            r_global_size <= IDX_W'(1);
            r_first_row   <= '0;
            r_local_rows  <= 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sras_pkg::CFG_INDEX_BASE:  r_index_base  <= i_cfg_data[0];
                sras_pkg::CFG_GLOBAL_SIZE: r_global_size <= i_cfg_data;
                sras_pkg::CFG_FIRST_ROW:   r_first_row   <= i_cfg_data[15:0];
                sras_pkg::CFG_LOCAL_ROWS:  r_local_rows  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_cmp_valid <= 1'b0;
            r_clr_cnt   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + RW'(1);
            end
            if (i_cmd.fill_rd) begin
                r_k         <= '0;
                r_cmp_valid <= 1'b0;
            end else if (adv) begin
                r_cmp_valid <= issue;
                if (issue) begin
                    r_k <= r_k + KW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= i_func;
            r_row   <= i_row;
            r_col   <= i_col;
            r_value <= i_value;
        end
        if (i_cmd.adjust) begin
            r_err_base <= r_index_base && ((r_row == '0) || (r_col == '0));
            r_row_a    <= r_row - IDX_W'(r_index_base);
            r_col_a    <= r_col - IDX_W'(r_index_base);
        end
        if (i_cmd.chk) begin
            if (r_err_base) begin
                r_status <= sras_pkg::ST_BELOW_BASE;
            end else if (beyond) begin
                r_status <= sras_pkg::ST_BEYOND_SIZE;
            end else if (not_local) begin
                r_status <= sras_pkg::ST_NOT_LOCAL;
            end else begin
                r_status <= sras_pkg::ST_OK;
            end
            r_r       <= row_off[RW-1:0];
            r_slot    <= '0;
            r_created <= 1'b0;
        end
        if (i_cmd.fill_rd) begin
            r_base <= AW'(r_r * CAP);
        end
        if (i_cmd.update) begin
            r_slot <= r_cmp_k;
        end
        if (i_cmd.append) begin
            if (full) begin
                r_status <= sras_pkg::ST_ROW_FULL;
            end else begin
                r_slot    <= r_fill_q;
                r_created <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status  <= r_status;
            r_out_slot    <= sras_pkg::SLOT_W'(r_slot);
            r_out_created <= r_created;
        end
    end

    // per-row fill counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            fill_mem[r_clr_cnt] <= '0;
        end else if (append_wr) begin
            fill_mem[r_r] <= r_fill_q + KW'(1);
        end
        if (i_cmd.fill_rd && (r_status == sras_pkg::ST_OK)) begin
            r_fill_q <= fill_mem[r_r];
        end
    end

    // entry stores, one read and one write address per cycle
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_col_q <= col_mem[rd_addr];
            r_val_q <= val_mem[rd_addr];
            r_cmp_k <= r_k;
        end
        if (append_wr) begin
            col_mem[wr_addr] <= r_col_a[COL_W-1:0];
            val_mem[wr_addr] <= r_value;
        end else if (i_cmd.update) begin
            val_mem[wr_addr] <= new_val;
        end
    end

    assign o_status  = r_out_status;
    assign o_slot    = r_out_slot;
    assign o_created = r_out_created;

    a_cmp_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (r_cmp_k < r_fill_q))
        else $error("compared slot lies beyond row fill");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search |-> (r_k <= r_fill_q))
        else $error("column scan ran past row fill");

    a_search_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search |-> (r_status == sras_pkg::ST_OK))
        else $error("search started on a rejected transaction");

endmodule

// ===== hw/rtl/sras_ctrl.sv =====
module sras_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sras_pkg::t_cmd   o_cmd,
    input  sras_pkg::t_stat  i_stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADJ,
        S_CHK,
        S_FILL,
        S_SEARCH,
        S_UPDATE,
        S_APPEND,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                o_cmd.adjust = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_rd = 1'b1;
                n_state = i_stat.err ? S_FINISH : S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_UPDATE;
                end else if (i_stat.miss) begin
                    n_state = S_APPEND;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = S_FINISH;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.load_out || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_hit_miss_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !(i_stat.hit && i_stat.miss))
        else $error("search reports hit and miss together");

endmodule

// ===== tb/sparse_row_assembly_store_top_tb.sv =====
module sparse_row_assembly_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W     = sras_pkg::IDX_W;
    localparam int COL_W     = sras_pkg::COL_W;
    localparam int VAL_W     = sras_pkg::VAL_W;
    localparam int STATUS_W  = sras_pkg::STATUS_W;
    localparam int SLOT_W    = sras_pkg::SLOT_W;
    localparam int CFG_W     = sras_pkg::CFG_W;
    localparam int CFG_IDX_W = sras_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE  = sras_pkg::CFG_INDEX_BASE;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_SIZE = sras_pkg::CFG_GLOBAL_SIZE;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW   = sras_pkg::CFG_FIRST_ROW;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ROWS  = sras_pkg::CFG_LOCAL_ROWS;

    localparam logic [IDX_W-1:0] GSIZE_MAX = sras_pkg::GSIZE_MAX;
    localparam logic [VAL_W-1:0] VAL_MAX   = sras_pkg::VAL_MAX;
    localparam logic [VAL_W-1:0] VAL_MIN   = sras_pkg::VAL_MIN;

    typedef sras_pkg::t_status t_status;

    localparam t_status ST_OK          = sras_pkg::ST_OK;
    localparam t_status ST_BELOW_BASE  = sras_pkg::ST_BELOW_BASE;
    localparam t_status ST_BEYOND_SIZE = sras_pkg::ST_BEYOND_SIZE;
    localparam t_status ST_NOT_LOCAL   = sras_pkg::ST_NOT_LOCAL;
    localparam t_status ST_ROW_FULL    = sras_pkg::ST_ROW_FULL;

    localparam int ROW_SLOTS = 256;
    localparam int ROW_CAP   = 16;
    localparam int PHASES    = 9;
    localparam int PHASE_ITEMS = 125;
    localparam int SETTLE_CYCLES = ROW_CAP + 12;
    localparam int MAX_REPORTS = 60;

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_ADD    = 1'b1;

    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic                 created;
    } t_outcome;

    typedef enum logic {STEP_WRITE, STEP_ENTRY} t_step_kind;

    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic                 func;
        logic [IDX_W-1:0]     row;
        logic [IDX_W-1:0]     col;
        logic [VAL_W-1:0]     value;
        logic [4:0]           rep;
        logic                 typed;
        t_outcome             outcome;
    } t_step;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_func;
    logic [IDX_W-1:0]        i_row;
    logic [IDX_W-1:0]        i_col;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [STATUS_W-1:0]     o_status;
    logic [SLOT_W-1:0]       o_slot;
    logic                    o_created;

    // shadow of the block's registers and row list
    logic                    reg_index_base;
    int unsigned             reg_global_size;
    int unsigned             reg_first_row;
    int unsigned             reg_local_rows;
    logic [4:0]              row_fill   [ROW_SLOTS];
    logic [COL_W-1:0]        col_store  [ROW_SLOTS*ROW_CAP];
    logic [VAL_W-1:0]        val_store  [ROW_SLOTS*ROW_CAP];

    t_outcome                pending_results [$];
    t_step                   plan [$];
    int                      fail_count = 0;
    int                      results_seen = 0;
    int                      send_idle_pct;
    int                      recv_idle_pct;
    int                      hold_left = 0;
    int                      next_hold_at = 150;

    sparse_row_assembly_store_top #(
        .ROWS (ROW_SLOTS),
        .CAP  (ROW_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_created   (o_created)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_outcome assemble_entry(input logic func,
                                                input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col,
                                                input logic [VAL_W-1:0] value);
        t_outcome    res;
        int unsigned gsz, lrows, r_idx, c_idx, offset, fill, at;
        logic [VAL_W:0] sum;
        res.status  = ST_OK;
        res.slot    = '0;
        res.created = 1'b0;
        gsz   = (reg_global_size > GSIZE_MAX) ? GSIZE_MAX : reg_global_size;
        lrows = (reg_local_rows > ROW_SLOTS) ? ROW_SLOTS : reg_local_rows;
        r_idx = row;
        c_idx = col;
        if (reg_index_base) begin
            if (row == 0 || col == 0) begin
                res.status = ST_BELOW_BASE;
                return res;
            end
            r_idx--;
            c_idx--;
        end
        if (r_idx >= gsz || c_idx >= gsz) begin
            res.status = ST_BEYOND_SIZE;
            return res;
        end
        if (r_idx < reg_first_row || r_idx - reg_first_row >= lrows) begin
            res.status = ST_NOT_LOCAL;
            return res;
        end
        offset = r_idx - reg_first_row;
        fill   = row_fill[offset];
        for (int k = 0; k < fill; k++) begin
            at = offset * ROW_CAP + k;
            if (col_store[at] == c_idx) begin
                if (func == FN_ADD) begin
                    sum = {val_store[at][VAL_W-1], val_store[at]} + {value[VAL_W-1], value};
                    // sign bits disagree on overflow: clamp toward the lost side
                    if (sum[VAL_W] != sum[VAL_W-1])
                        val_store[at] = sum[VAL_W] ? VAL_MIN : VAL_MAX;
                    else
                        val_store[at] = sum[VAL_W-1:0];
                end else begin
                    val_store[at] = value;
                end
                res.slot = SLOT_W'(k);
                return res;
            end
        end
        if (fill >= ROW_CAP) begin
            res.status = ST_ROW_FULL;
            return res;
        end
        at = offset * ROW_CAP + fill;
        col_store[at]    = COL_W'(c_idx);
        val_store[at]    = value;
        row_fill[offset] = 5'(fill + 1);
        res.slot         = SLOT_W'(fill);
        res.created      = 1'b1;
        return res;
    endfunction

    function automatic t_step reg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
        t_step s;
        s         = '0;
        s.kind    = STEP_WRITE;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic t_step entry_step(input logic func, input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [VAL_W-1:0] value,
                                         input logic [4:0] rep);
        t_step s;
        s       = '0;
        s.kind  = STEP_ENTRY;
        s.func  = func;
        s.row   = row;
        s.col   = col;
        s.value = value;
        s.rep   = rep;
        return s;
    endfunction

    function automatic t_step known_step(input logic func, input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [VAL_W-1:0] value,
                                         input t_status status,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic created);
        t_step s;
        s                 = entry_step(func, row, col, value, 5'd1);
        s.typed           = 1'b1;
        s.outcome.status  = status;
        s.outcome.slot    = slot;
        s.outcome.created = created;
        return s;
    endfunction

    function automatic int unsigned any_index();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return GSIZE_MAX;
            default: return $urandom_range(0, GSIZE_MAX);
        endcase
    endfunction

    task automatic offer_entry(input logic func, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value,
                               input logic typed, input t_outcome typed_res);
        t_outcome predicted;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_row      <= row;
        i_col      <= col;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        predicted = assemble_entry(func, row, col, value);
        pending_results.push_back(typed ? typed_res : predicted);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // drain all outstanding transactions, then give the block time to go idle
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_INDEX_BASE:  reg_index_base  = val[0];
            CFG_GLOBAL_SIZE: reg_global_size = val[16:0];
            CFG_FIRST_ROW:   reg_first_row   = val[15:0];
            CFG_LOCAL_ROWS:  reg_local_rows  = val[8:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: status %0d slot %0d created %0d",
                             $time, o_status, o_slot, o_created);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                end
                if (o_slot !== want.slot) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: slot expected %0d actual %0d",
                                 $time, want.slot, o_slot);
                end
                if (o_created !== want.created) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: created expected %0d actual %0d",
                                 $time, want.created, o_created);
                end
            end
        end
        // long hold-offs let the block back up into its input
        if (hold_left != 0)
            hold_left--;
        else if (results_seen >= next_hold_at) begin
            hold_left    = 200;
            next_hold_at = next_hold_at + 550;
        end
        i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int unsigned pick_base, pick_gsize, pick_first, pick_lrows;
        int unsigned gsz_eff, lrows_eff, row_hi, hot_lo, hot_hi, col_lo;
        int unsigned row_i, col_i;
        logic [VAL_W-1:0] val;
        int sel;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_INDEX_BASE;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_func        <= FN_INSERT;
        i_row         <= '0;
        i_col         <= '0;
        i_value       <= '0;
        i_out_stall   <= 1'b0;
        send_idle_pct = 24;
        recv_idle_pct <= 82;

        reg_index_base  = 1'b0;
        reg_global_size = 1;
        reg_first_row   = 0;
        reg_local_rows  = 1;
        foreach (row_fill[i]) row_fill[i] = '0;

        // first local row is global 100 (one-based 101), three rows held
        plan.push_back(reg_step(CFG_INDEX_BASE, 1));
        plan.push_back(reg_step(CFG_GLOBAL_SIZE, 17'h1FFFF));
        plan.push_back(reg_step(CFG_FIRST_ROW, 100));
        plan.push_back(reg_step(CFG_LOCAL_ROWS, 3));
        plan.push_back(known_step(FN_INSERT, 0, 5, 32'h0001_0000, ST_BELOW_BASE, 0, 0));
        plan.push_back(known_step(FN_ADD, 0, 65536, VAL_MAX, ST_BELOW_BASE, 0, 0));
        plan.push_back(known_step(FN_INSERT, 65536, 1, 32'h0000_0001, ST_NOT_LOCAL, 0, 0));
        plan.push_back(known_step(FN_INSERT, 101, 65536, VAL_MAX, ST_OK, 0, 1));
        plan.push_back(known_step(FN_ADD, 101, 65536, 32'h0000_0001, ST_OK, 0, 0));
        plan.push_back(known_step(FN_ADD, 101, 1, VAL_MIN, ST_OK, 1, 1));
        plan.push_back(known_step(FN_ADD, 101, 1, VAL_MIN, ST_OK, 1, 0));
        plan.push_back(known_step(FN_INSERT, 100, 3, 32'h0000_8000, ST_NOT_LOCAL, 0, 0));
        plan.push_back(known_step(FN_INSERT, 104, 3, 32'h0000_8000, ST_NOT_LOCAL, 0, 0));
        // fill the row to capacity, then append to and update the full row
        plan.push_back(entry_step(FN_INSERT, 101, 2, 32'hFFFF_8000, 5'd14));
        plan.push_back(known_step(FN_INSERT, 101, 99, 32'h0003_0000, ST_ROW_FULL, 0, 0));
        plan.push_back(known_step(FN_INSERT, 101, 65536, 32'h0000_0000, ST_OK, 0, 0));
        plan.push_back(reg_step(CFG_INDEX_BASE, 0));
        plan.push_back(reg_step(CFG_GLOBAL_SIZE, 0));
        plan.push_back(known_step(FN_INSERT, 0, 0, 32'h0000_0000, ST_BEYOND_SIZE, 0, 0));
        plan.push_back(reg_step(CFG_GLOBAL_SIZE, 1));
        plan.push_back(reg_step(CFG_FIRST_ROW, 0));
        plan.push_back(reg_step(CFG_LOCAL_ROWS, 1));
        plan.push_back(entry_step(FN_ADD, 0, 0, 32'h0002_0000, 5'd1));
        plan.push_back(known_step(FN_INSERT, 0, 1, 32'h0002_0000, ST_BEYOND_SIZE, 0, 0));
        plan.push_back(reg_step(CFG_GLOBAL_SIZE, GSIZE_MAX));
        plan.push_back(reg_step(CFG_LOCAL_ROWS, 9'h1FF));
        plan.push_back(known_step(FN_INSERT, 256, 0, 32'h0000_0010, ST_NOT_LOCAL, 0, 0));
        plan.push_back(known_step(FN_ADD, 255, 65535, VAL_MIN, ST_OK, 0, 1));
        plan.push_back(known_step(FN_INSERT, 65536, 0, 32'h0000_0010, ST_BEYOND_SIZE, 0, 0));
        plan.push_back(reg_step(CFG_FIRST_ROW, 65535));
        plan.push_back(entry_step(FN_INSERT, 65535, 65535, 32'h7FFF_0000, 5'd1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // row fill counts are cleared before the block takes input
        do @(posedge i_clk); while (o_in_stall !== 1'b0);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_WRITE) begin
                settle_block();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                for (int j = 0; j < plan[i].rep; j++)
                    offer_entry(plan[i].func, plan[i].row, IDX_W'(plan[i].col + j),
                                plan[i].value, plan[i].typed, plan[i].outcome);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    pick_base = 0; pick_gsize = GSIZE_MAX;
                    pick_first = 0; pick_lrows = ROW_SLOTS;
                end
                1: begin
                    pick_base = 1; pick_gsize = 17'h1FFFF;
                    pick_first = 65280; pick_lrows = ROW_SLOTS;
                end
                2: begin
                    pick_base = 0; pick_gsize = 30;
                    pick_first = $urandom_range(0, 29); pick_lrows = 1;
                end
                default: begin
                    pick_base  = $urandom_range(0, 1);
                    pick_gsize = ($urandom_range(0, 3) == 0) ? GSIZE_MAX
                                                             : $urandom_range(1, GSIZE_MAX);
                    pick_first = $urandom_range(0, pick_gsize - 1);
                    pick_lrows = $urandom_range(1, ROW_SLOTS);
                end
            endcase
            settle_block();
            write_reg(CFG_INDEX_BASE, CFG_W'(pick_base));
            write_reg(CFG_GLOBAL_SIZE, CFG_W'(pick_gsize));
            write_reg(CFG_FIRST_ROW, CFG_W'(pick_first));
            write_reg(CFG_LOCAL_ROWS, CFG_W'(pick_lrows));

            if (ph < 3) begin
                send_idle_pct = 24;
                recv_idle_pct <= 82;
            end else if (ph < 6) begin
                send_idle_pct = 82;
                recv_idle_pct <= 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end

            // a few hot rows and a column pool larger than a row holds
            gsz_eff   = (pick_gsize > GSIZE_MAX) ? GSIZE_MAX : pick_gsize;
            lrows_eff = (pick_lrows > ROW_SLOTS) ? ROW_SLOTS : pick_lrows;
            row_hi    = pick_first + lrows_eff;
            if (row_hi > gsz_eff) row_hi = gsz_eff;
            row_hi    = row_hi - 1;
            hot_lo    = $urandom_range(pick_first, row_hi);
            hot_hi    = (hot_lo + 3 > row_hi) ? row_hi : hot_lo + 3;
            col_lo    = (gsz_eff > 24) ? $urandom_range(0, gsz_eff - 24) : 0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == 60) settle_block();
                sel = $urandom_range(0, 99);
                if (sel < 78) begin
                    row_i = (sel < 8) ? $urandom_range(pick_first, row_hi)
                                      : $urandom_range(hot_lo, hot_hi);
                    col_i = col_lo + $urandom_range(0, 23);
                    if (col_i >= gsz_eff) col_i = gsz_eff - 1;
                    row_i = row_i + pick_base;
                    col_i = col_i + pick_base;
                end else begin
                    row_i = any_index();
                    col_i = any_index();
                end
                case ($urandom_range(0, 9))
                    8:       val = VAL_MAX - $urandom_range(0, 255);
                    9:       val = VAL_MIN + $urandom_range(0, 255);
                    default: val = $urandom;
                endcase
                offer_entry(1'($urandom_range(0, 1)), IDX_W'(row_i), IDX_W'(col_i), val,
                            1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
